>>> design/cc_pkg.sv
// Shared types, codes, constants and calendar tables for the calendar clock.
// Used by cc_weekday, cc_datapath, cc_ctrl and calendar_clock.
package cc_pkg;

    localparam int unsigned MS_PER_SECOND_DEF = 1000;

    // Operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_INVAL = 2'd2;

    localparam logic [11:0] YEAR_MIN   = 12'd2024;
    localparam logic [11:0] YEAR_MAX   = 12'd2099;
    localparam logic [11:0] YEAR_RST   = 12'd2026;
    localparam logic [12:0] YEAR_SHIFT = 13'd400;

    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [4:0] HOUR_LAST  = 5'd23;
    localparam logic [5:0] MIN_LAST   = 6'd59;
    localparam logic [5:0] SEC_LAST   = 6'd59;

    // Reciprocals: x/100 = (x*5243)>>19 exact below 2^15, x/7 = (x*9363)>>16 below 8192
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;
    localparam logic [13:0] RECIP_7         = 14'd9363;
    localparam int          RECIP_7_SHIFT   = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOOP,
        ST_WSTART,
        ST_WWAIT,
        ST_FINISH
    } cc_state_t;

    typedef struct packed {
        logic latch_in;
        logic tick_base;
        logic tick_arm;
        logic do_set;
        logic do_inval;
        logic step;
        logic wd_start;
        logic load_out;
    } cc_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       valid;
        logic       base_empty;
        logic       set_ok;
        logic       second_due;
        logic       day_roll;
        logic       wd_done;
    } cc_stat_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [2:0] month_offset(input logic [3:0] month);
        logic [2:0] off;
        case (month)
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

    function automatic logic [6:0] day_bit(input logic [2:0] w);
        logic [6:0] mask;
        case (w)
            3'd1:    mask = 7'd2;
            3'd2:    mask = 7'd4;
            3'd3:    mask = 7'd8;
            3'd4:    mask = 7'd16;
            3'd5:    mask = 7'd32;
            3'd6:    mask = 7'd64;
            default: mask = 7'd1;
        endcase
        return mask;
    endfunction

endpackage

>>> design/cc_weekday.sv
// Three-stage weekday unit (Sakamoto) with leap-year flag of the current year.
// Depends on cc_pkg for reciprocal constants and tables.
module cc_weekday
    import cc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [11:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    output logic        done,
    output logic [6:0]  mask,
    output logic        leap
);

    logic        v1_reg, v2_reg, v3_reg;
    logic [12:0] yy_reg;
    logic [5:0]  q100_reg;
    logic [5:0]  yq_reg;
    logic [5:0]  od_reg;
    logic [11:0] year_reg;
    logic [12:0] sum_reg;
    logic [12:0] sum2_reg;
    logic [9:0]  q7_reg;
    logic        leap_reg;

    logic [12:0] yy;
    logic [25:0] yy_prod;
    logic [25:0] yr_prod;
    logic [12:0] sum;
    logic [11:0] yrem;
    logic [26:0] s_prod;
    logic [12:0] wrem;

    always_comb begin
        // Shift by 400 years keeps the weekday and avoids going negative
        yy      = 13'(year) + YEAR_SHIFT - ((month < 4'd3) ? 13'd1 : 13'd0);
        yy_prod = 26'(yy) * 26'(RECIP_100);
        yr_prod = 26'(year) * 26'(RECIP_100);
        sum     = yy_reg + (yy_reg >> 2) - 13'(q100_reg) + 13'(q100_reg >> 2)
                  + 13'(od_reg);
        yrem    = year_reg - 12'(yq_reg) * 12'd100;
        s_prod  = 27'(sum_reg) * 27'(RECIP_7);
        wrem    = sum2_reg - 13'(q7_reg) * 13'd7;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            yy_reg   <= yy;
            q100_reg <= yy_prod[RECIP_100_SHIFT +: 6];
            yq_reg   <= yr_prod[RECIP_100_SHIFT +: 6];
            od_reg   <= 6'(month_offset(month)) + 6'(day);
            year_reg <= year;
        end
        if (v1_reg) begin
            sum_reg  <= sum;
            leap_reg <= (year_reg[1:0] == 2'b00) && ((yrem != 12'd0) || (yq_reg[1:0] == 2'b00));
        end
        if (v2_reg) begin
            sum2_reg <= sum_reg;
            q7_reg   <= s_prod[RECIP_7_SHIFT +: 10];
        end
    end

    assign done = v3_reg;
    assign mask = day_bit(wrem[2:0]);
    assign leap = leap_reg;

endmodule

>>> design/cc_datapath.sv
// Datapath: input latch, calendar registers, second stepper and result register.
// Depends on cc_pkg and cc_weekday.
module cc_datapath
    import cc_pkg::*;
#(
    parameter int unsigned MS_PER_SECOND = MS_PER_SECOND_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cc_cmd_t     cmd,
    output cc_stat_t    stat,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_now_ms,
    input  logic [11:0] s_set_year,
    input  logic [3:0]  s_set_month,
    input  logic [4:0]  s_set_day,
    input  logic [4:0]  s_set_hour,
    input  logic [5:0]  s_set_minute,
    input  logic [5:0]  s_set_second,
    output logic        m_clock_valid,
    output logic        m_set_accepted,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second,
    output logic [6:0]  m_weekday_mask,
    output logic [10:0] m_minute_of_day,
    output logic [16:0] m_second_of_day
);

    localparam logic [31:0] MS = 32'(MS_PER_SECOND);

    // Latched input transfer
    logic [1:0]  op_reg;
    logic [31:0] now_reg;
    logic [11:0] sy_reg;
    logic [3:0]  sm_reg;
    logic [4:0]  sd_reg;
    logic [4:0]  sh_reg;
    logic [5:0]  smi_reg;
    logic [5:0]  ss_reg;

    // Clock state
    logic        valid_reg,    valid_next;
    logic        accepted_reg, accepted_next;
    logic [31:0] last_reg,     last_next;
    logic [31:0] delta_reg,    delta_next;
    logic [11:0] year_reg,     year_next;
    logic [3:0]  month_reg,    month_next;
    logic [4:0]  day_reg,      day_next;
    logic [4:0]  hour_reg,     hour_next;
    logic [5:0]  minute_reg,   minute_next;
    logic [5:0]  second_reg,   second_next;
    logic [6:0]  wday_reg,     wday_next;
    logic        leap_reg,     leap_next;

    logic        wd_done;
    logic [6:0]  wd_mask;
    logic        wd_leap;
    logic        day_roll;
    logic        set_ok;

    cc_weekday u_weekday (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.wd_start),
        .year    (year_reg),
        .month   (month_reg),
        .day     (day_reg),
        .done    (wd_done),
        .mask    (wd_mask),
        .leap    (wd_leap)
    );

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg  <= s_operation;
            now_reg <= s_now_ms;
            sy_reg  <= s_set_year;
            sm_reg  <= s_set_month;
            sd_reg  <= s_set_day;
            sh_reg  <= s_set_hour;
            smi_reg <= s_set_minute;
            ss_reg  <= s_set_second;
        end
    end

    always_comb begin
        day_roll = (second_reg == SEC_LAST) && (minute_reg == MIN_LAST)
                   && (hour_reg == HOUR_LAST);
        // Within 2024..2099 a year divisible by four is always leap
        set_ok   = (sy_reg >= YEAR_MIN) && (sy_reg <= YEAR_MAX)
                   && (sm_reg >= 4'd1) && (sm_reg <= MONTH_MAX)
                   && (sd_reg >= 5'd1)
                   && (sd_reg <= month_days(sm_reg, sy_reg[1:0] == 2'b00))
                   && (sh_reg <= HOUR_LAST) && (smi_reg <= MIN_LAST)
                   && (ss_reg <= SEC_LAST);

        stat.op         = op_reg;
        stat.valid      = valid_reg;
        stat.base_empty = (last_reg == 32'd0);
        stat.set_ok     = set_ok;
        stat.second_due = (delta_reg >= MS);
        stat.day_roll   = day_roll;
        stat.wd_done    = wd_done;
    end

    always_comb begin
        valid_next    = valid_reg;
        accepted_next = accepted_reg;
        last_next     = last_reg;
        delta_next    = delta_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        wday_next     = wday_reg;
        leap_next     = leap_reg;

        if (cmd.latch_in) begin
            accepted_next = 1'b0;
        end
        if (cmd.tick_base) begin
            last_next = now_reg;
        end
        if (cmd.tick_arm) begin
            delta_next = now_reg - last_reg;
        end
        if (cmd.do_set) begin
            year_next     = sy_reg;
            month_next    = sm_reg;
            day_next      = sd_reg;
            hour_next     = sh_reg;
            minute_next   = smi_reg;
            second_next   = ss_reg;
            valid_next    = 1'b1;
            accepted_next = 1'b1;
            last_next     = now_reg;
            delta_next    = 32'd0;
        end
        if (cmd.do_inval) begin
            valid_next = 1'b0;
            last_next  = 32'd0;
        end
        if (cmd.step) begin
            delta_next = delta_reg - MS;
            last_next  = last_reg + MS;
            if (second_reg != SEC_LAST) begin
                second_next = second_reg + 6'd1;
            end else begin
                second_next = 6'd0;
                if (minute_reg != MIN_LAST) begin
                    minute_next = minute_reg + 6'd1;
                end else begin
                    minute_next = 6'd0;
                    if (hour_reg != HOUR_LAST) begin
                        hour_next = hour_reg + 5'd1;
                    end else begin
                        hour_next = 5'd0;
                        if (day_reg >= month_days(month_reg, leap_reg)) begin
                            day_next = 5'd1;
                            if (month_reg >= MONTH_MAX) begin
                                month_next = 4'd1;
                                year_next  = year_reg + 12'd1;
                            end else begin
                                month_next = month_reg + 4'd1;
                            end
                        end else begin
                            day_next = day_reg + 5'd1;
                        end
                    end
                end
            end
        end
        if (wd_done) begin
            wday_next = wd_mask;
            leap_next = wd_leap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            accepted_reg <= 1'b0;
            last_reg     <= 32'd0;
            delta_reg    <= 32'd0;
            year_reg     <= YEAR_RST;
            month_reg    <= 4'd1;
            day_reg      <= 5'd1;
            hour_reg     <= 5'd0;
            minute_reg   <= 6'd0;
            second_reg   <= 6'd0;
            wday_reg     <= 7'd1;
            leap_reg     <= 1'b0;
        end else begin
            valid_reg    <= valid_next;
            accepted_reg <= accepted_next;
            last_reg     <= last_next;
            delta_reg    <= delta_next;
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
            wday_reg     <= wday_next;
            leap_reg     <= leap_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_clock_valid   <= valid_reg;
            m_set_accepted  <= accepted_reg;
            m_year          <= year_reg;
            m_month         <= month_reg;
            m_day           <= day_reg;
            m_hour          <= hour_reg;
            m_minute        <= minute_reg;
            m_second        <= second_reg;
            m_weekday_mask  <= wday_reg;
            m_minute_of_day <= 11'(hour_reg) * 11'd60 + 11'(minute_reg);
            m_second_of_day <= 17'(hour_reg) * 17'd3600 + 17'(minute_reg) * 17'd60
                               + 17'(second_reg);
        end
    end

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (second_reg <= SEC_LAST) && (minute_reg <= MIN_LAST) && (hour_reg <= HOUR_LAST))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (month_reg >= 4'd1) && (month_reg <= MONTH_MAX) && (day_reg >= 5'd1))
        else $error("month or day out of range");

    a_wday_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(wday_reg))
        else $error("weekday mask not one-hot");

    a_step_due: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (delta_reg >= MS))
        else $error("second stepped without a whole second elapsed");

    a_day_roll: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && day_roll) |=>
            (hour_reg == 5'd0) && (minute_reg == 6'd0) && (second_reg == 6'd0))
        else $error("day rollover left time of day non-zero");

endmodule

>>> design/cc_ctrl.sv
// Controller state machine: sequences operations, second stepping and weekday updates.
// Depends on cc_pkg for the state, command and status types.
module cc_ctrl
    import cc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  cc_stat_t stat,
    output cc_cmd_t  cmd
);

    cc_state_t state_reg, state_next;
    logic      m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FINISH;
                case (stat.op)
                    OP_TICK: begin
                        if (stat.valid && stat.base_empty) begin
                            cmd.tick_base = 1'b1;
                        end else if (stat.valid) begin
                            cmd.tick_arm = 1'b1;
                            state_next   = ST_LOOP;
                        end
                    end
                    OP_SET: begin
                        if (stat.set_ok) begin
                            cmd.do_set = 1'b1;
                            state_next = ST_WSTART;
                        end
                    end
                    OP_INVAL: begin
                        cmd.do_inval = 1'b1;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_LOOP: begin
                if (stat.second_due) begin
                    cmd.step = 1'b1;
                    // Hold the loop while the weekday is recomputed after a day change
                    if (stat.day_roll) begin
                        state_next = ST_WSTART;
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_WSTART: begin
                cmd.wd_start = 1'b1;
                state_next   = ST_WWAIT;
            end
            ST_WWAIT: begin
                if (stat.wd_done) begin
                    state_next = ST_LOOP;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> design/calendar_clock.sv
// Calendar clock top level: controller plus datapath behind valid/ready channels.
// Depends on cc_pkg, cc_ctrl and cc_datapath.
//
// One operation per input transfer (tick with a millisecond stamp, set, invalidate)
// and one result per operation, showing the clock after it. Items are handled one
// at a time by a controller that steps a single second per clock cycle, pausing at
// each day change while the weekday unit recomputes. A tick steps once per whole
// second elapsed; an accepted set also runs the weekday unit. The result sits in an
// output register, so the next transfer is taken while a result waits.
module calendar_clock
    import cc_pkg::*;
#(
    parameter int unsigned MS_PER_SECOND = MS_PER_SECOND_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_now_ms,
    input  logic [11:0] s_set_year,
    input  logic [3:0]  s_set_month,
    input  logic [4:0]  s_set_day,
    input  logic [4:0]  s_set_hour,
    input  logic [5:0]  s_set_minute,
    input  logic [5:0]  s_set_second,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_clock_valid,
    output logic        m_set_accepted,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second,
    output logic [6:0]  m_weekday_mask,
    output logic [10:0] m_minute_of_day,
    output logic [16:0] m_second_of_day
);

    cc_cmd_t  cmd;
    cc_stat_t stat;

    cc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cc_datapath #(
        .MS_PER_SECOND (MS_PER_SECOND)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_operation     (s_operation),
        .s_now_ms        (s_now_ms),
        .s_set_year      (s_set_year),
        .s_set_month     (s_set_month),
        .s_set_day       (s_set_day),
        .s_set_hour      (s_set_hour),
        .s_set_minute    (s_set_minute),
        .s_set_second    (s_set_second),
        .m_clock_valid   (m_clock_valid),
        .m_set_accepted  (m_set_accepted),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day           (m_day),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second),
        .m_weekday_mask  (m_weekday_mask),
        .m_minute_of_day (m_minute_of_day),
        .m_second_of_day (m_second_of_day)
    );

endmodule
